// ===== rtl/core/tsi_pkg.sv =====
// Shared types and constants for the trace segment intercept block.
// No dependencies; used by the top level, the divider and the checker.
`default_nettype none
package tsi_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIV_STEPS  = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_DELTA_X  = 3'd2;
  localparam logic [2:0] REG_DELTA_Y  = 3'd3;
  localparam logic [2:0] REG_EARLY    = 3'd4;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_BEHIND = 2'd1;
  localparam logic [1:0] VERDICT_RECORD = 2'd2;
  localparam logic [1:0] VERDICT_STOP   = 2'd3;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic crossed;
    logic is_obj;
    logic two_sided;
    logic den_zero;
    logic sat;
    logic neg;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/tsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
// Depends on tsi_pkg (DIV_STEPS, ctl_t).
`default_nettype none
module tsi_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire tsi_pkg::ctl_t      in_ctl,
  input  wire logic [32:0]        aa,
  input  wire logic [32:0]        ab,
  output logic                    out_v,
  output tsi_pkg::ctl_t           out_ctl,
  output logic [31:0]             quo
);

  logic                 v    [0:tsi_pkg::DIV_STEPS];
  tsi_pkg::ctl_t        ctl  [0:tsi_pkg::DIV_STEPS];
  logic [32:0]          rem  [0:tsi_pkg::DIV_STEPS];
  logic [31:0]          low  [0:tsi_pkg::DIV_STEPS];
  logic [31:0]          q    [0:tsi_pkg::DIV_STEPS];
  logic [32:0]          dsr  [0:tsi_pkg::DIV_STEPS];

  // prep stage: dividend is aa << 16; top bits seed the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= in_ctl;
      rem[0] <= {16'd0, aa[32:16]};
      low[0] <= {aa[15:0], 16'd0};
      q[0]   <= '0;
      dsr[0] <= ab;
    end
  end

  for (genvar k = 0; k < tsi_pkg::DIV_STEPS; k++) begin : g_step
    logic [33:0] t;
    logic [33:0] diff;
    logic        ge;

    assign t    = {rem[k], low[k][31]};
    assign diff = t - {1'b0, dsr[k]};
    assign ge   = t >= {1'b0, dsr[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[k+1] <= ctl[k];
        rem[k+1] <= ge ? diff[32:0] : t[32:0];
        low[k+1] <= {low[k][30:0], 1'b0};
        q[k+1]   <= {q[k][30:0], ge};
        dsr[k+1] <= dsr[k];
      end
    end
  end

  assign out_v   = v[tsi_pkg::DIV_STEPS];
  assign out_ctl = ctl[tsi_pkg::DIV_STEPS];
  assign quo     = q[tsi_pkg::DIV_STEPS];

endmodule
`default_nettype wire

// ===== rtl/core/trace_segment_intercept.sv =====
// Trace segment intercept: top level with trace registers and the pipeline.
// Depends on tsi_pkg and tsi_div.
// A word passes through stages 1 to 5, the divider and the output register, all registered.
// Throughput: one word per cycle; the stages move together and freeze only
// when the last divider stage holds a result and the output register is stalled.
// Reset (rst, synchronous) clears all valid bits and the trace registers to 0.
`default_nettype none
module trace_segment_intercept (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic signed [31:0] point_a_x,
  input  wire logic signed [31:0] point_a_y,
  input  wire logic signed [31:0] point_b_x,
  input  wire logic signed [31:0] point_b_y,
  input  wire logic [23:0]        radius,
  input  wire logic               two_sided,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              verdict,
  output logic signed [31:0]      fraction
);

  localparam logic signed [31:0] LONG_TRACE = 32'sh0010_0000;  // 16.0
  localparam logic signed [31:0] ONE_FX     = 32'sh0001_0000;

  // operands of one side test
  typedef struct packed {
    logic               spec;   // answered without multiply
    logic               sval;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } side_op_t;

  function automatic logic signed [31:0] fmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return p[47:16];
  endfunction

  function automatic side_op_t side_prep(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] lx, input logic signed [31:0] ly,
      input logic signed [31:0] ldx, input logic signed [31:0] ldy,
      input logic fine);
    side_op_t           o;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    dx     = px - lx;
    dy     = py - ly;
    o.spec = 1'b0;
    o.sval = 1'b0;
    if (ldx == 0) begin
      o.spec = 1'b1;
      o.sval = (px <= lx) ? (ldy > 0) : (ldy < 0);
    end else if (ldy == 0) begin
      o.spec = 1'b1;
      o.sval = (py <= ly) ? (ldx < 0) : (ldx > 0);
    end else if (fine && (ldy[31] ^ ldx[31] ^ dx[31] ^ dy[31])) begin
      // sign-bit shortcut
      o.spec = 1'b1;
      o.sval = ldy[31] ^ dx[31];
    end
    if (fine) begin
      o.a = ldy >>> 8;
      o.b = dx >>> 8;
      o.c = dy >>> 8;
      o.d = ldx >>> 8;
    end else begin
      o.a = ldy >>> 16;
      o.b = dx;
      o.c = dy;
      o.d = ldx >>> 16;
    end
    return o;
  endfunction

  // ---------------- trace registers ----------------
  logic signed [31:0] tox, toy, tdx, tdy;
  logic               early_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      tox       <= '0;
      toy       <= '0;
      tdx       <= '0;
      tdy       <= '0;
      early_out <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsi_pkg::REG_ORIGIN_X: tox       <= cfg_data;
        tsi_pkg::REG_ORIGIN_Y: toy       <= cfg_data;
        tsi_pkg::REG_DELTA_X:  tdx       <= cfg_data;
        tsi_pkg::REG_DELTA_Y:  tdy       <= cfg_data;
        tsi_pkg::REG_EARLY:    early_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Whole pipe advances together; it holds only when the divider's last
  // stage has a word and the output register cannot take it.
  logic          en;
  logic          div_v;
  tsi_pkg::ctl_t div_ctl;
  logic [31:0]   div_q;
  logic          hold;

  assign hold     = div_v && out_valid && out_stall;
  assign en       = !hold;
  assign in_stall = hold;

  // ---------------- stage 1: capture word ----------------
  logic               v1;
  logic               r1_obj, r1_two;
  logic signed [31:0] r1_ax, r1_ay, r1_bx, r1_by;
  logic [23:0]        r1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_obj <= opcode;
      r1_two <= two_sided;
      r1_ax  <= point_a_x;
      r1_ay  <= point_a_y;
      r1_bx  <= point_b_x;
      r1_by  <= point_b_y;
      r1_r   <= radius;
    end
  end

  // ---------------- stage 2: pick points and lines ----------------
  logic signed [31:0] rr;
  logic               pos_diag, long_trace, fine_c;
  logic signed [31:0] x1_c, y1_c, x2_c, y2_c;

  assign rr         = {8'd0, r1_r};
  assign pos_diag   = (tdx[31] == tdy[31]) && (tdx != tdy);
  assign long_trace = (tdx > LONG_TRACE) || (tdy > LONG_TRACE) ||
                      (tdx < -LONG_TRACE) || (tdy < -LONG_TRACE);
  assign fine_c     = r1_obj || long_trace;

  // an object is cut along one diagonal of its bounding square
  assign x1_c = r1_obj ? r1_ax - rr : r1_ax;
  assign x2_c = r1_obj ? r1_ax + rr : r1_bx;
  assign y1_c = r1_obj ? (pos_diag ? r1_ay + rr : r1_ay - rr) : r1_ay;
  assign y2_c = r1_obj ? (pos_diag ? r1_ay - rr : r1_ay + rr) : r1_by;

  logic               v2;
  logic               r2_obj, r2_two, r2_fine;
  logic signed [31:0] r2_p1x, r2_p1y, r2_p2x, r2_p2y;
  logic signed [31:0] r2_lx, r2_ly, r2_ldx, r2_ldy;
  logic signed [31:0] r2_x1, r2_y1, r2_x2, r2_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_obj  <= r1_obj;
      r2_two  <= r1_two;
      r2_fine <= fine_c;
      r2_x1   <= x1_c;
      r2_y1   <= y1_c;
      r2_x2   <= x2_c;
      r2_y2   <= y2_c;
      if (fine_c) begin
        // segment ends against the trace
        r2_p1x <= x1_c;
        r2_p1y <= y1_c;
        r2_p2x <= x2_c;
        r2_p2y <= y2_c;
        r2_lx  <= tox;
        r2_ly  <= toy;
        r2_ldx <= tdx;
        r2_ldy <= tdy;
      end else begin
        // trace ends against the segment
        r2_p1x <= tox;
        r2_p1y <= toy;
        r2_p2x <= tox + tdx;
        r2_p2y <= toy + tdy;
        r2_lx  <= r1_ax;
        r2_ly  <= r1_ay;
        r2_ldx <= r1_bx - r1_ax;
        r2_ldy <= r1_by - r1_ay;
      end
    end
  end

  // ---------------- stage 3: multiplier operands ----------------
  side_op_t           op1_c, op2_c;
  logic signed [31:0] ildx_c, ildy_c;

  assign op1_c  = side_prep(r2_p1x, r2_p1y, r2_lx, r2_ly, r2_ldx, r2_ldy, r2_fine);
  assign op2_c  = side_prep(r2_p2x, r2_p2y, r2_lx, r2_ly, r2_ldx, r2_ldy, r2_fine);
  assign ildx_c = r2_x2 - r2_x1;
  assign ildy_c = r2_y2 - r2_y1;

  logic               v3;
  logic               r3_obj, r3_two;
  side_op_t           r3_op1, r3_op2;
  logic signed [31:0] r3_ildx, r3_ildy, r3_ndx, r3_ndy, r3_sdx, r3_sdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_obj  <= r2_obj;
      r3_two  <= r2_two;
      r3_op1  <= op1_c;
      r3_op2  <= op2_c;
      r3_ildx <= ildx_c;
      r3_ildy <= ildy_c;
      r3_sdy  <= ildy_c >>> 8;
      r3_sdx  <= ildx_c >>> 8;
      r3_ndx  <= (r2_x1 - tox) >>> 8;
      r3_ndy  <= (toy - r2_y1) >>> 8;
    end
  end

  // ---------------- stage 4: products ----------------
  logic               v4;
  logic               r4_obj, r4_two;
  logic               r4_spec1, r4_sval1, r4_spec2, r4_sval2;
  logic signed [31:0] r4_l1, r4_rt1, r4_l2, r4_rt2;
  logic signed [31:0] r4_den_a, r4_den_b, r4_num_a, r4_num_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_obj   <= r3_obj;
      r4_two   <= r3_two;
      r4_spec1 <= r3_op1.spec;
      r4_sval1 <= r3_op1.sval;
      r4_spec2 <= r3_op2.spec;
      r4_sval2 <= r3_op2.sval;
      r4_l1    <= fmul(r3_op1.a, r3_op1.b);
      r4_rt1   <= fmul(r3_op1.c, r3_op1.d);
      r4_l2    <= fmul(r3_op2.a, r3_op2.b);
      r4_rt2   <= fmul(r3_op2.c, r3_op2.d);
      r4_den_a <= fmul(r3_sdy, tdx);
      r4_den_b <= fmul(r3_sdx, tdy);
      r4_num_a <= fmul(r3_ndx, r3_ildy);
      r4_num_b <= fmul(r3_ndy, r3_ildx);
    end
  end

  // ---------------- stage 5: sides, numerator, denominator ----------------
  logic s1_c, s2_c;

  assign s1_c = r4_spec1 ? r4_sval1 : !(r4_rt1 < r4_l1);
  assign s2_c = r4_spec2 ? r4_sval2 : !(r4_rt2 < r4_l2);

  logic               v5;
  logic               r5_obj, r5_two, r5_crossed;
  logic signed [31:0] r5_num, r5_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_obj     <= r4_obj;
      r5_two     <= r4_two;
      r5_crossed <= s1_c != s2_c;
      r5_num     <= r4_num_a + r4_num_b;
      r5_den     <= r4_den_a - r4_den_b;
    end
  end

  // ---------------- divider ----------------
  logic [32:0]   aa_c, ab_c;
  tsi_pkg::ctl_t ctl_c;

  assign aa_c = r5_num[31] ? 33'd0 - {r5_num[31], r5_num} : {1'b0, r5_num};
  assign ab_c = r5_den[31] ? 33'd0 - {r5_den[31], r5_den} : {1'b0, r5_den};

  always_comb begin
    ctl_c.crossed   = r5_crossed;
    ctl_c.is_obj    = r5_obj;
    ctl_c.two_sided = r5_two;
    ctl_c.den_zero  = r5_den == 0;
    ctl_c.sat       = (aa_c >> 14) >= ab_c;   // quotient magnitude would be 2^30 or more
    ctl_c.neg       = r5_num[31] ^ r5_den[31];
  end

  tsi_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (v5),
    .in_ctl  (ctl_c),
    .aa      (aa_c),
    .ab      (ab_c),
    .out_v   (div_v),
    .out_ctl (div_ctl),
    .quo     (div_q)
  );

  // ---------------- final: sign, saturation, verdict ----------------
  logic signed [31:0] frac_c;
  logic signed [31:0] frac_out_c;
  logic [1:0]         verdict_c;

  always_comb begin
    if (div_ctl.den_zero) begin
      frac_c = '0;                       // parallel lines
    end else if (div_ctl.sat) begin
      frac_c = div_ctl.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      frac_c = div_ctl.neg ? -$signed(div_q) : $signed(div_q);
    end

    frac_out_c = '0;
    if (!div_ctl.crossed) begin
      verdict_c = tsi_pkg::VERDICT_NONE;
    end else if (frac_c[31]) begin
      verdict_c = tsi_pkg::VERDICT_BEHIND;
    end else begin
      frac_out_c = frac_c;
      if (!div_ctl.is_obj && early_out && (frac_c < ONE_FX) && !div_ctl.two_sided) begin
        verdict_c = tsi_pkg::VERDICT_STOP;
      end else begin
        verdict_c = tsi_pkg::VERDICT_RECORD;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      verdict  <= verdict_c;
      fraction <= frac_out_c;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsi_check.sv =====
// Port-level checker for trace_segment_intercept and its bind statement.
// Depends on tsi_pkg for verdict codes.
`default_nettype none
module tsi_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         verdict,
  input wire logic signed [31:0] fraction
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(fraction))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == tsi_pkg::VERDICT_NONE || verdict == tsi_pkg::VERDICT_BEHIND)
      |-> fraction == 0)
    else $error("fraction not zero for a miss");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == tsi_pkg::VERDICT_STOP |-> fraction[31:16] == 16'd0)
    else $error("early stop outside the trace");

  a_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == tsi_pkg::VERDICT_RECORD |-> !fraction[31])
    else $error("recorded intercept behind source");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind trace_segment_intercept tsi_check u_tsi_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict),
  .fraction  (fraction)
);
`default_nettype wire
